@@ hdl/upd_pkg.sv @@
package upd_pkg;

   // Character codes used by the decoder.
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

   // Decoder phase within an escape sequence.
   typedef enum logic [1:0] {
      PHASE_PLAIN = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_HEX1  = 2'd2
   } upd_phase_type;

   // One byte of the encoded string.
   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } upd_req_type;

   // One decoder result.
   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_valid;
      logic       string_end;
      logic       decode_error;
   } upd_rsp_type;

   // Hex digit decode: bit 4 set when the character is a hex digit, bits 3:0 its value.
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            hex_decode = {1'b1, diff[3:0]};
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            diff = c - CHAR_LOWER_A;
            hex_decode = {1'b1, diff[3:0] + HEX_LETTER_BASE};
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            diff = c - CHAR_UPPER_A;
            hex_decode = {1'b1, diff[3:0] + HEX_LETTER_BASE};
         end else begin
            hex_decode = 5'd0;
         end
      end
   endfunction

   // Unreserved characters, and the reserved characters other than '+', that are copied unchanged.
   function automatic logic passes_through(input logic [7:0] c);
      begin
         if ((c >= CHAR_ZERO && c <= CHAR_NINE) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)) begin
            passes_through = 1'b1;
         end else begin
            case (c)
               "-", "_", ".", "~", ":", "/", "?", "#", "[", "]", "@",
               "!", "$", "&", "'", "(", ")", "*", ",", ";", "=": begin
                  passes_through = 1'b1;
               end
               default: begin
                  passes_through = 1'b0;
               end
            endcase
         end
      end
   endfunction

endpackage

@@ hdl/url_percent_decoder.sv @@
// Streaming URL percent-decoder. One byte of the encoded string is taken per transfer on
// the req_ channel, with is_last set on the final byte; an empty string cannot be sent.
// '%' and two hex digits of either case give the byte they spell, '+' gives a space, and
// letters, digits and the usual URI punctuation are copied. A result is delivered on the
// rsp_ channel for every decoded byte and for every last byte; the last byte's result has
// string_end set and reports in decode_error whether the string was malformed (a bad
// character, a bad hex digit or an end inside an escape). Once a string is malformed no
// further bytes are delivered for it. The block takes one byte every cycle unless the rsp_
// channel stalls: a byte is held in the input register and is then decoded into the result
// register, and a stall only holds the pipeline while rsp_ready is low.
module url_percent_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  upd_pkg::upd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output upd_pkg::upd_rsp_type rsp_data
);

   // Input register.
   logic                  in_valid_ff;
   upd_pkg::upd_req_type  in_data_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   upd_pkg::upd_rsp_type  rsp_data_ff;
   upd_pkg::upd_rsp_type  rsp_data_in;

   // Decoder state.
   upd_pkg::upd_phase_type phase_ff;
   upd_pkg::upd_phase_type phase_in;
   logic [3:0]             high_nibble_ff;
   logic [3:0]             high_nibble_in;
   logic                   error_seen_ff;
   logic                   error_seen_in;

   logic                   advance;
   logic [4:0]             hex;
   logic                   byte_valid;
   logic [7:0]             byte_value;
   logic                   err_next;
   upd_pkg::upd_phase_type phase_next;

   // The held byte moves on when the result register is free or is being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Decode of the held byte against the current phase.
   always_comb begin
      hex            = upd_pkg::hex_decode(in_data_ff.char_in);
      byte_valid     = 1'b0;
      byte_value     = 8'd0;
      phase_next     = phase_ff;
      high_nibble_in = high_nibble_ff;
      err_next       = error_seen_ff;
      if (!error_seen_ff) begin
         case (phase_ff)
            upd_pkg::PHASE_PCT: begin
               if (hex[4]) begin
                  high_nibble_in = hex[3:0];
                  phase_next     = upd_pkg::PHASE_HEX1;
               end else begin
                  err_next = 1'b1;
               end
            end
            upd_pkg::PHASE_HEX1: begin
               if (hex[4]) begin
                  byte_value = {high_nibble_ff, hex[3:0]};
                  byte_valid = 1'b1;
                  phase_next = upd_pkg::PHASE_PLAIN;
               end else begin
                  err_next = 1'b1;
               end
            end
            default: begin
               phase_next = upd_pkg::PHASE_PLAIN;
               if (in_data_ff.char_in == upd_pkg::CHAR_PERCENT) begin
                  phase_next = upd_pkg::PHASE_PCT;
               end else if (in_data_ff.char_in == upd_pkg::CHAR_PLUS) begin
                  byte_value = upd_pkg::CHAR_SPACE;
                  byte_valid = 1'b1;
               end else if (upd_pkg::passes_through(in_data_ff.char_in)) begin
                  byte_value = in_data_ff.char_in;
                  byte_valid = 1'b1;
               end else begin
                  err_next = 1'b1;
               end
            end
         endcase
         // A string must not end part-way through an escape.
         if (in_data_ff.is_last && phase_next != upd_pkg::PHASE_PLAIN) begin
            err_next = 1'b1;
         end
      end

      // Result for this byte.
      rsp_valid_in             = byte_valid || in_data_ff.is_last;
      rsp_data_in.byte_out     = byte_value;
      rsp_data_in.byte_valid   = byte_valid;
      rsp_data_in.string_end   = in_data_ff.is_last;
      rsp_data_in.decode_error = in_data_ff.is_last && err_next;

      // The state clears after the last byte of a string.
      if (in_data_ff.is_last) begin
         phase_in       = upd_pkg::PHASE_PLAIN;
         high_nibble_in = 4'd0;
         error_seen_in  = 1'b0;
      end else begin
         phase_in      = phase_next;
         error_seen_in = err_next;
      end
   end

   // Input register: loaded on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Decoder state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= upd_pkg::PHASE_PLAIN;
         high_nibble_ff <= 4'd0;
         error_seen_ff  <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff   <= rsp_valid_in;
            phase_ff       <= phase_in;
            high_nibble_ff <= high_nibble_in;
            error_seen_ff  <= error_seen_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
